// ----- rtl/tecs_pkg.sv -----
// Shared types and constants for the touch event coordinate scaler.
// Holds event codes, register indexes, reset values, the controller state
// and the command/status structs. No dependencies.
`timescale 1ns / 1ps

package tecs_pkg;

  localparam int PTR_W     = 12;
  localparam int SCR_REG_W = 13;
  localparam int CFG_IW    = 3;

  localparam logic [15:0] EVT_SYN = 16'h0000;
  localparam logic [15:0] EVT_KEY = 16'h0001;
  localparam logic [15:0] EVT_ABS = 16'h0003;

  localparam logic [15:0] CODE_AX_X       = 16'h0000;
  localparam logic [15:0] CODE_AX_Y       = 16'h0001;
  localparam logic [15:0] CODE_MT_X       = 16'h0035;
  localparam logic [15:0] CODE_MT_Y       = 16'h0036;
  localparam logic [15:0] CODE_MT_TRACK   = 16'h0039;
  localparam logic [15:0] CODE_TOUCH_KEY  = 16'h014A;
  localparam logic [15:0] CODE_SYN_REPORT = 16'h0000;

  localparam logic [31:0] TRACK_NONE = 32'hFFFF_FFFF;

  localparam logic [CFG_IW-1:0] REG_X_MIN = 3'd0;
  localparam logic [CFG_IW-1:0] REG_X_MAX = 3'd1;
  localparam logic [CFG_IW-1:0] REG_Y_MIN = 3'd2;
  localparam logic [CFG_IW-1:0] REG_Y_MAX = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SCR_W = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SCR_H = 3'd5;

  localparam logic [31:0]          X_MIN_RST = 32'd0;
  localparam logic [31:0]          X_MAX_RST = 32'd4095;
  localparam logic [31:0]          Y_MIN_RST = 32'd0;
  localparam logic [31:0]          Y_MAX_RST = 32'd4095;
  localparam logic [SCR_REG_W-1:0] SCR_W_RST = 13'd800;
  localparam logic [SCR_REG_W-1:0] SCR_H_RST = 13'd480;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_COMMIT,
    ST_POST
  } state_t;

  typedef struct packed {
    logic load_event;
    logic mul;
    logic step;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_sync;
  } sts_t;

endpackage

// ----- rtl/touch_event_coordinate_scaler_top.sv -----
// Touch event coordinate scaler, top level. Non-sync requests: latch the event, then
// hand off the result. Sync-report requests: a multiply step,
// 32+log2(MAX_SCREEN_DIM) restoring divider steps (both axes in parallel), a commit
// and a hand-off; a new request is taken only after the result has been handed off,
// and a waiting result holds the hand-off. Synchronous reset restores register
// defaults, clears raw latches, lane results and pressed flag; no clearing pass.
`timescale 1ns / 1ps

module touch_event_coordinate_scaler_top #(
  parameter int MAX_SCREEN_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [15:0]                  event_type,
  input  logic [15:0]                  event_code,
  input  logic signed [31:0]           event_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tecs_pkg::PTR_W-1:0]   pointer_x,
  output logic [tecs_pkg::PTR_W-1:0]   pointer_y,
  output logic                         pointer_pressed,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tecs_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam int DIV_STEPS = 32 + $clog2(MAX_SCREEN_DIM);

  tecs_pkg::cmd_t cmd;
  tecs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  tecs_ctrl #(.DIV_STEPS(DIV_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tecs_dpath #(.MAX_SCREEN_DIM(MAX_SCREEN_DIM)) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .event_type      (event_type),
    .event_code      (event_code),
    .event_value     (event_value),
    .cmd             (cmd),
    .sts             (sts),
    .pointer_x       (pointer_x),
    .pointer_y       (pointer_y),
    .pointer_pressed (pointer_pressed)
  );

  a_sync_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_event && sts.is_sync) |=> cmd.mul)
    else $error("sync request did not start multiply");

  a_mul_then_step: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> cmd.step)
    else $error("divider did not follow multiply");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_event, cmd.mul, cmd.step, cmd.commit, cmd.load_out}))
    else $error("overlapping datapath commands");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

endmodule

// ----- rtl/tecs_axis.sv -----
// One scaling lane: calibration multiply, restoring divider, clamp to screen.
// Depends on tecs_pkg for the command struct and pointer width.
`timescale 1ns / 1ps

module tecs_axis #(
  parameter int MAX_SCREEN_DIM = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tecs_pkg::cmd_t                   cmd,
  input  logic signed [31:0]               raw,
  input  logic signed [31:0]               mn,
  input  logic signed [31:0]               mx,
  input  logic [tecs_pkg::SCR_REG_W-1:0]   dim_reg,
  output logic [tecs_pkg::PTR_W-1:0]       screen
);

  localparam int MW = $clog2(MAX_SCREEN_DIM);
  localparam int DW = $clog2(MAX_SCREEN_DIM + 1);
  localparam int PW = 34 + MW;
  localparam int QW = 32 + MW;

  function automatic logic [DW-1:0] eff_dim(input logic [tecs_pkg::SCR_REG_W-1:0] r);
    logic [31:0] r32;
    r32 = 32'(r);
    if (r32 == 32'd0) begin
      return DW'(1);
    end else if (r32 > 32'(MAX_SCREEN_DIM)) begin
      return DW'(MAX_SCREEN_DIM);
    end
    return DW'(r32);
  endfunction

  logic [DW-1:0]        d;
  logic [MW-1:0]        dm1;
  logic [31:0]          d32;
  logic signed [32:0]   diff;
  logic signed [32:0]   den33;
  logic signed [PW-1:0] prod;
  logic                 cal;

  logic [QW-1:0]        num;
  logic [31:0]          rem;
  logic [31:0]          den;
  logic                 neg;
  logic                 cal_r;

  logic [32:0]          rem_sh;
  logic                 fits;
  logic [31:0]          v32;

  assign d     = eff_dim(dim_reg);
  assign dm1   = MW'(d - DW'(1));
  assign d32   = 32'(d);
  assign diff  = $signed({raw[31], raw}) - $signed({mn[31], mn});
  assign den33 = $signed({mx[31], mx}) - $signed({mn[31], mn});
  assign prod  = diff * $signed({1'b0, dm1});
  assign cal   = mx > mn;

  assign rem_sh = {rem, num[QW-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_comb begin
    if (cal_r) begin
      if (neg) begin
        v32 = 32'd0;
      end else if (num >= QW'(d)) begin
        v32 = d32 - 32'd1;
      end else begin
        v32 = num[31:0];
      end
    end else begin
      if (raw < 0) begin
        v32 = 32'd0;
      end else if (raw >= $signed(d32)) begin
        v32 = d32 - 32'd1;
      end else begin
        v32 = $unsigned(raw);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num   <= prod[QW-1:0];
      neg   <= prod[PW-1];
      rem   <= 32'd0;
      den   <= den33[31:0];
      cal_r <= cal;
    end else if (cmd.step) begin
      rem <= fits ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
      num <= {num[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen <= '0;
    end else if (cmd.commit) begin
      screen <= v32[tecs_pkg::PTR_W-1:0];
    end
  end

endmodule

// ----- rtl/tecs_dpath.sv -----
// Datapath: configuration registers, raw axis latches, pressed flag,
// two scaling lanes and the result register. Depends on tecs_pkg, tecs_axis.
`timescale 1ns / 1ps

module tecs_dpath #(
  parameter int MAX_SCREEN_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tecs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic [15:0]                    event_type,
  input  logic [15:0]                    event_code,
  input  logic signed [31:0]             event_value,
  input  tecs_pkg::cmd_t                 cmd,
  output tecs_pkg::sts_t                 sts,
  output logic [tecs_pkg::PTR_W-1:0]     pointer_x,
  output logic [tecs_pkg::PTR_W-1:0]     pointer_y,
  output logic                           pointer_pressed
);

  logic signed [31:0]              x_min, x_max, y_min, y_max;
  logic [tecs_pkg::SCR_REG_W-1:0]  scr_w, scr_h;
  logic signed [31:0]              raw_x, raw_y;
  logic                            touch_down;
  logic [tecs_pkg::PTR_W-1:0]      screen_x, screen_y;

  assign sts.is_sync = (event_type == tecs_pkg::EVT_SYN) &&
                       (event_code == tecs_pkg::CODE_SYN_REPORT);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= tecs_pkg::X_MIN_RST;
      x_max <= tecs_pkg::X_MAX_RST;
      y_min <= tecs_pkg::Y_MIN_RST;
      y_max <= tecs_pkg::Y_MAX_RST;
      scr_w <= tecs_pkg::SCR_W_RST;
      scr_h <= tecs_pkg::SCR_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tecs_pkg::REG_X_MIN: x_min <= cfg_data;
        tecs_pkg::REG_X_MAX: x_max <= cfg_data;
        tecs_pkg::REG_Y_MIN: y_min <= cfg_data;
        tecs_pkg::REG_Y_MAX: y_max <= cfg_data;
        tecs_pkg::REG_SCR_W: scr_w <= cfg_data[tecs_pkg::SCR_REG_W-1:0];
        tecs_pkg::REG_SCR_H: scr_h <= cfg_data[tecs_pkg::SCR_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // latch raw axes and pressed flag from accepted requests that carry them
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_x      <= '0;
      raw_y      <= '0;
      touch_down <= 1'b0;
    end else if (cmd.load_event) begin
      priority if (event_type == tecs_pkg::EVT_ABS) begin
        priority if (event_code == tecs_pkg::CODE_AX_X ||
                     event_code == tecs_pkg::CODE_MT_X) begin
          raw_x <= event_value;
        end else if (event_code == tecs_pkg::CODE_AX_Y ||
                     event_code == tecs_pkg::CODE_MT_Y) begin
          raw_y <= event_value;
        end else if (event_code == tecs_pkg::CODE_MT_TRACK) begin
          touch_down <= (event_value != tecs_pkg::TRACK_NONE);
        end else begin
        end
      end else if (event_type == tecs_pkg::EVT_KEY &&
                   event_code == tecs_pkg::CODE_TOUCH_KEY) begin
        touch_down <= (event_value != 32'sd0);
      end else begin
      end
    end
  end

  tecs_axis #(.MAX_SCREEN_DIM(MAX_SCREEN_DIM)) u_axis_x (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .raw     (raw_x),
    .mn      (x_min),
    .mx      (x_max),
    .dim_reg (scr_w),
    .screen  (screen_x)
  );

  tecs_axis #(.MAX_SCREEN_DIM(MAX_SCREEN_DIM)) u_axis_y (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .raw     (raw_y),
    .mn      (y_min),
    .mx      (y_max),
    .dim_reg (scr_h),
    .screen  (screen_y)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pointer_x       <= screen_x;
      pointer_y       <= screen_y;
      pointer_pressed <= touch_down;
    end
  end

endmodule

// ----- rtl/tecs_ctrl.sv -----
// Controller: sequences accept, multiply, divider steps, commit and result
// hand-off. Depends on tecs_pkg for state, command and status types.
`timescale 1ns / 1ps

module tecs_ctrl #(
  parameter int DIV_STEPS = 44
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tecs_pkg::sts_t  sts,
  output tecs_pkg::cmd_t  cmd
);

  localparam int CW = $clog2(DIV_STEPS);

  tecs_pkg::state_t state, state_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tecs_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      tecs_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_event = in_valid;
        if (in_valid) begin
          state_next = sts.is_sync ? tecs_pkg::ST_MUL : tecs_pkg::ST_POST;
        end
      end
      tecs_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = '0;
        state_next = tecs_pkg::ST_DIV;
      end
      tecs_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt == CW'(DIV_STEPS - 1)) begin
          state_next = tecs_pkg::ST_COMMIT;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      tecs_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = tecs_pkg::ST_POST;
      end
      tecs_pkg::ST_POST: begin
        // hold until the result slot is free
        cmd.load_out = !out_valid || out_ready;
        if (cmd.load_out) begin
          state_next = tecs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tecs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule
